// File: hdl/kpd_pkg.sv
// shared types, mode codes and character helpers for the kernel parameter parser
package kpd_pkg;

  // parse modes
  localparam logic [4:0] M_SEARCH   = 5'd0;
  localparam logic [4:0] M_ENTRY_WS = 5'd1;
  localparam logic [4:0] M_NAME     = 5'd2;
  localparam logic [4:0] M_TO_PAREN = 5'd3;
  localparam logic [4:0] M_TOP      = 5'd4;
  localparam logic [4:0] M_SKIP     = 5'd5;
  localparam logic [4:0] M_PKW      = 5'd6;
  localparam logic [4:0] M_AFTER_P  = 5'd7;
  localparam logic [4:0] M_AKW      = 5'd8;
  localparam logic [4:0] M_AWS1     = 5'd9;
  localparam logic [4:0] M_ADIG     = 5'd10;
  localparam logic [4:0] M_AWS2     = 5'd11;
  localparam logic [4:0] M_TYPE     = 5'd12;
  localparam logic [4:0] M_PNAME    = 5'd13;
  localparam logic [4:0] M_AR_WS    = 5'd14;
  localparam logic [4:0] M_AR_POS   = 5'd15;
  localparam logic [4:0] M_AR_NEG   = 5'd16;
  localparam logic [4:0] M_AR_DONE  = 5'd17;

  // event kinds
  localparam logic [1:0] EV_NAME  = 2'd0;
  localparam logic [1:0] EV_PARAM = 2'd1;
  localparam logic [1:0] EV_END   = 2'd2;

  localparam logic [2:0] KW_LEN = 3'd6;

  localparam logic [7:0] KW_ENTRY [6] = '{8'h2E, 8'h65, 8'h6E, 8'h74, 8'h72, 8'h79};
  localparam logic [7:0] KW_PARAM [6] = '{8'h2E, 8'h70, 8'h61, 8'h72, 8'h61, 8'h6D};
  localparam logic [7:0] KW_ALIGN [6] = '{8'h2E, 8'h61, 8'h6C, 8'h69, 8'h67, 8'h6E};

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  name_char;
    logic [31:0] param_bytes;
    logic [31:0] param_alignment;
    logic [31:0] param_offset;
    logic [31:0] buffer_total;
    logic        last;
  } evt_t;

  // results of one byte: up to two events
  typedef struct packed {
    logic [1:0] count;
    evt_t       ev0;
    evt_t       ev1;
  } step_out_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C || c == 8'h0D;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           c == 8'h5F;
  endfunction

  // size of a type token, 8 when unknown
  function automatic logic [4:0] type_size(input logic [3:0] len, input logic [7:0] c0,
                                           input logic [7:0] c1, input logic [7:0] c2,
                                           input logic [7:0] c3);
    logic usb;
    logic usbf;
    logic [4:0] sz;
    usb  = c0 == 8'h75 || c0 == 8'h73 || c0 == 8'h62;
    usbf = usb || c0 == 8'h66;
    sz   = 5'd8;
    case (len)
      4'd2: if (usb && c1 == 8'h38) sz = 5'd1;
      4'd3: begin
        if (usbf && c1 == 8'h31 && c2 == 8'h36) sz = 5'd2;
        else if (usbf && c1 == 8'h33 && c2 == 8'h32) sz = 5'd4;
      end
      4'd4: begin
        if ((c0 == 8'h75 || c0 == 8'h62) && c1 == 8'h31 && c2 == 8'h32 && c3 == 8'h38)
          sz = 5'd16;
      end
      default: sz = 5'd8;
    endcase
    return sz;
  endfunction

endpackage

// File: hdl/kpd_parse.sv
// parser state and the per-byte update that produces up to two events
module kpd_parse import kpd_pkg::*; #(
  parameter int TYPE_TOKEN_MAX = 4,
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output step_out_t  result
);

  localparam int LW = $clog2(TYPE_TOKEN_MAX + 1);
  localparam int IW = $clog2(TYPE_TOKEN_MAX);
  localparam int VW = VALUE_WIDTH;
  localparam logic [LW-1:0] TMAX = LW'(TYPE_TOKEN_MAX);
  localparam logic [VW-1:0] ONE = VW'(1);
  localparam logic [VW-1:0] FOUR = VW'(4);
  localparam logic [VW-1:0] SEVEN = VW'(7);

  logic [4:0]    parse_mode, parse_mode_next;
  logic [2:0]    keyword_progress, keyword_progress_next;
  logic [7:0]    type_chars [TYPE_TOKEN_MAX];
  logic [7:0]    type_chars_next [TYPE_TOKEN_MAX];
  logic [LW-1:0] type_length, type_length_next;
  logic          type_too_long, type_too_long_next;
  logic [4:0]    current_size, current_size_next;
  logic [VW-1:0] array_count, array_count_next;
  logic [VW-1:0] running_offset, running_offset_next;
  logic          name_nonempty, name_nonempty_next;

  logic f_name, f_enter, f_end, f_param, f_apply, f_neg, f_acc, f_clr, f_ft, f_start, f_add;
  logic [VW-1:0] ac0, ac1, sz, al, off, ro_base, ro_p, total;
  logic [VW+4:0] prod;
  logic [4:0]    cs;
  evt_t          name_ev, par_ev, end_ev;
  logic          pe, ee;

  // control walk: a byte may be looked at by up to three modes
  always_comb begin
    logic [4:0] m;
    logic [2:0] kp;
    logic again;
    logic [7:0] c;
    c = text_byte;
    m = parse_mode;
    kp = keyword_progress;
    again = 1'b1;
    name_nonempty_next = name_nonempty;
    {f_name, f_enter, f_end, f_param, f_apply, f_neg, f_acc, f_clr, f_ft, f_start, f_add} = '0;
    for (int p = 0; p < 3; p++) begin
      if (again) begin
        again = 1'b0;
        unique case (m)
          M_SEARCH: begin
            if (kp < KW_LEN && c == KW_ENTRY[kp]) begin
              kp = kp + 3'd1;
              if (kp == KW_LEN) begin
                m = M_ENTRY_WS;
                name_nonempty_next = 1'b0;
              end
            end else begin
              kp = (c == 8'h2E) ? 3'd1 : 3'd0;
            end
          end
          M_ENTRY_WS: begin
            if (is_ws(c)) begin
            end else if (c == 8'h28) begin
              f_enter = 1'b1;
              m = M_TOP;
            end else begin
              name_nonempty_next = 1'b1;
              f_name = 1'b1;
              m = M_NAME;
            end
          end
          M_NAME: begin
            if (c == 8'h28) begin
              f_enter = 1'b1;
              m = M_TOP;
            end else if (is_ws(c)) m = M_TO_PAREN;
            else f_name = 1'b1;
          end
          M_TO_PAREN: begin
            if (c == 8'h28) begin
              f_enter = 1'b1;
              m = M_TOP;
            end
          end
          M_TOP: begin
            if (c == 8'h29 || c == 8'h7B) begin
              f_end = 1'b1;
              m = M_SEARCH;
              kp = 3'd0;
            end else if (is_ws(c) || c == 8'h2C) begin
            end else if (c == 8'h2E) begin
              m = M_PKW;
              kp = 3'd1;
            end else m = M_SKIP;
          end
          M_SKIP: begin
            if (c == 8'h2C) m = M_TOP;
            else if (c == 8'h29) begin
              f_end = 1'b1;
              m = M_SEARCH;
              kp = 3'd0;
            end
          end
          M_PKW: begin
            if (kp < KW_LEN && c == KW_PARAM[kp]) begin
              kp = kp + 3'd1;
              if (kp == KW_LEN) m = M_AFTER_P;
            end else begin
              m = M_SKIP;
              again = 1'b1;
            end
          end
          M_AFTER_P: begin
            if (is_ws(c)) begin
            end else if (c == 8'h2E) begin
              m = M_AKW;
              kp = 3'd1;
              f_start = 1'b1;
            end else begin
              m = M_TOP;
              again = 1'b1;
            end
          end
          M_AKW: begin
            if (kp < KW_LEN && c == KW_ALIGN[kp]) begin
              f_add = 1'b1;
              kp = kp + 3'd1;
              if (kp == KW_LEN) m = M_AWS1;
            end else if (is_word(c)) begin
              f_add = 1'b1;
              m = M_TYPE;
            end else begin
              f_ft = 1'b1;
              m = M_PNAME;
              again = 1'b1;
            end
          end
          M_AWS1: begin
            if (is_ws(c)) begin
            end else if (is_digit(c)) m = M_ADIG;
            else begin
              m = M_AWS2;
              again = 1'b1;
            end
          end
          M_ADIG: begin
            if (!is_digit(c)) begin
              m = M_AWS2;
              again = 1'b1;
            end
          end
          M_AWS2: begin
            if (is_ws(c)) begin
            end else if (c == 8'h2E) begin
              f_start = 1'b1;
              m = M_TYPE;
            end else begin
              m = M_TOP;
              again = 1'b1;
            end
          end
          M_TYPE: begin
            if (is_word(c)) f_add = 1'b1;
            else begin
              f_ft = 1'b1;
              m = M_PNAME;
              again = 1'b1;
            end
          end
          M_PNAME: begin
            if (c == 8'h2C || c == 8'h29 || c == 8'h7B) begin
              f_param = 1'b1;
              m = M_TOP;
              again = 1'b1;
            end else if (c == 8'h5B) begin
              f_clr = 1'b1;
              m = M_AR_WS;
            end
          end
          M_AR_WS: begin
            if (c == 8'h5D) begin
              f_apply = 1'b1;
              f_param = 1'b1;
              m = M_TOP;
            end else if (is_ws(c)) begin
            end else if (c == 8'h2B) m = M_AR_POS;
            else if (c == 8'h2D) m = M_AR_NEG;
            else if (is_digit(c)) begin
              f_acc = 1'b1;
              m = M_AR_POS;
            end else m = M_AR_DONE;
          end
          M_AR_POS: begin
            if (is_digit(c)) f_acc = 1'b1;
            else if (c == 8'h5D) begin
              f_apply = 1'b1;
              f_param = 1'b1;
              m = M_TOP;
            end else m = M_AR_DONE;
          end
          M_AR_NEG: begin
            if (is_digit(c)) f_acc = 1'b1;
            else begin
              f_neg = 1'b1;
              if (c == 8'h5D) begin
                f_apply = 1'b1;
                f_param = 1'b1;
                m = M_TOP;
              end else m = M_AR_DONE;
            end
          end
          M_AR_DONE: begin
            if (c == 8'h5D) begin
              f_apply = 1'b1;
              f_param = 1'b1;
              m = M_TOP;
            end
          end
          default: begin
            m = M_SEARCH;
            kp = 3'd0;
          end
        endcase
      end
    end
    // end of text closes whatever kernel is open
    if (end_of_text) begin
      case (m)
        M_TOP, M_SKIP, M_PKW, M_AFTER_P, M_AWS1, M_ADIG, M_AWS2: f_end = 1'b1;
        M_AKW, M_TYPE: begin
          f_ft = 1'b1;
          f_param = 1'b1;
          f_end = 1'b1;
        end
        M_PNAME: begin
          f_param = 1'b1;
          f_end = 1'b1;
        end
        M_AR_NEG: begin
          f_neg = 1'b1;
          f_apply = 1'b1;
          f_param = 1'b1;
          f_end = 1'b1;
        end
        M_AR_WS, M_AR_POS, M_AR_DONE: begin
          f_apply = 1'b1;
          f_param = 1'b1;
          f_end = 1'b1;
        end
        default: begin
        end
      endcase
      m = M_SEARCH;
      kp = 3'd0;
    end
    parse_mode_next = m;
    keyword_progress_next = kp;
  end

  // type token capture
  always_comb begin
    type_chars_next = type_chars;
    type_length_next = type_length;
    type_too_long_next = type_too_long;
    if (f_start) begin
      type_length_next = '0;
      type_too_long_next = 1'b0;
    end else if (f_add) begin
      if (type_length < TMAX) begin
        type_chars_next[type_length[IW-1:0]] = text_byte;
        type_length_next = type_length + LW'(1);
      end else begin
        type_too_long_next = 1'b1;
      end
    end
  end

  // size, array count and offset arithmetic
  always_comb begin
    if (f_ft) begin
      cs = type_too_long_next ? 5'd8 :
           type_size(4'(type_length_next), type_chars_next[0], type_chars_next[1],
                     type_chars_next[2], type_chars_next[3]);
    end else begin
      cs = current_size;
    end
    current_size_next = cs;
    ac0 = f_clr ? '0 : array_count;
    ac1 = f_acc ? VW'((ac0 << 3) + (ac0 << 1) + VW'(text_byte[3:0])) : ac0;
    array_count_next = f_neg ? VW'('0 - ac1) : ac1;
    prod = array_count_next * cs;
    sz = (f_apply && array_count_next > ONE) ? prod[VW-1:0] : VW'(cs);
    al = (sz > FOUR) ? sz : FOUR;
    ro_base = f_enter ? '0 : running_offset;
    off = VW'(ro_base + al - ONE) & ~VW'(al - ONE);
    ro_p = VW'(off + sz);
    running_offset_next = f_param ? ro_p : ro_base;
    total = VW'(running_offset_next + SEVEN) & ~SEVEN;
  end

  // event assembly
  always_comb begin
    pe = f_param && name_nonempty_next;
    ee = f_end && name_nonempty_next;
    name_ev = '0;
    name_ev.kind = EV_NAME;
    name_ev.name_char = text_byte;
    par_ev = '0;
    par_ev.kind = EV_PARAM;
    par_ev.param_bytes = 32'(sz);
    par_ev.param_alignment = 32'(al);
    par_ev.param_offset = 32'(off);
    end_ev = '0;
    end_ev.kind = EV_END;
    end_ev.buffer_total = 32'(total);
    result = '0;
    if (f_name) begin
      result.count = 2'd1;
      result.ev0 = name_ev;
      result.ev0.last = 1'b1;
    end else if (pe && ee) begin
      result.count = 2'd2;
      result.ev0 = par_ev;
      result.ev1 = end_ev;
      result.ev1.last = 1'b1;
    end else if (pe) begin
      result.count = 2'd1;
      result.ev0 = par_ev;
      result.ev0.last = 1'b1;
    end else if (ee) begin
      result.count = 2'd1;
      result.ev0 = end_ev;
      result.ev0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode <= M_SEARCH;
      keyword_progress <= '0;
      type_length <= '0;
      type_too_long <= 1'b0;
      current_size <= '0;
      array_count <= '0;
      running_offset <= '0;
      name_nonempty <= 1'b0;
    end else if (step) begin
      parse_mode <= parse_mode_next;
      keyword_progress <= keyword_progress_next;
      type_length <= type_length_next;
      type_too_long <= type_too_long_next;
      current_size <= current_size_next;
      array_count <= array_count_next;
      running_offset <= running_offset_next;
      name_nonempty <= name_nonempty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) type_chars <= type_chars_next;
  end

endmodule

// File: hdl/kpd_queue.sv
// four-entry result queue taking up to two events per cycle
module kpd_queue import kpd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  step_out_t din,
  input  logic      pop,
  output logic      dout_valid,
  output evt_t      dout,
  output logic      room
);

  evt_t       mem [4];
  logic [1:0] rd_ptr, wr_ptr;
  logic [2:0] count;
  logic [1:0] n_in;
  logic       do_pop;

  assign n_in = push ? din.count : 2'd0;
  assign dout_valid = count != 3'd0;
  assign dout = mem[rd_ptr];
  assign room = count <= 3'd2;
  assign do_pop = pop && dout_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      rd_ptr <= rd_ptr + 2'(do_pop);
      wr_ptr <= wr_ptr + n_in;
      count <= count + 3'(n_in) - 3'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) mem[wr_ptr] <= din.ev0;
    if (n_in == 2'd2) mem[wr_ptr + 2'd1] <= din.ev1;
  end

endmodule

// File: hdl/kernel_param_decl_parser.sv
// top level of the kernel parameter declaration parser
//
// input stream: one text byte per request on s_axis, tlast marks the last byte
// of a text. output stream: one event per request on m_axis; tuser carries the
// kind (name byte, parameter, kernel end), tlast marks the last event of a byte.
// a byte is held in an input register; once the queue has room it updates the
// parser state in one pass of shallow logic and its events (at most two)
// are written into a four-entry queue whose head drives m_axis.
// throughput: one byte per cycle; a byte enters the parser only when the
// queue has two free entries, so bytes that give two events, or a stalled
// receiver, hold s_axis_tready low until the queue drains one event a cycle.
// reset (rst, synchronous) returns the parser to the keyword search and
// empties the register and queue; the end of a text does the same to the
// parser after its final events are queued.
module kernel_param_decl_parser import kpd_pkg::*; #(
  parameter int TYPE_TOKEN_MAX = 4,
  parameter int VALUE_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // text_byte
  input  logic         s_axis_tlast,   // end_of_text
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,   // name_char, param_bytes, param_alignment,
                                       // param_offset, buffer_total
  output logic [1:0]   m_axis_tuser,   // event_kind
  output logic         m_axis_tlast    // run_last
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eot;
  logic       take;
  logic       room;
  step_out_t  step_res;
  evt_t       head;

  // byte leaves the input register when the queue can absorb two events
  assign take = in_valid && room;
  assign s_axis_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_eot <= s_axis_tlast;
    end
  end

  kpd_parse #(
    .TYPE_TOKEN_MAX(TYPE_TOKEN_MAX),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_parse (
    .clk(clk),
    .rst(rst),
    .step(take),
    .text_byte(in_byte),
    .end_of_text(in_eot),
    .result(step_res)
  );

  kpd_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(take),
    .din(step_res),
    .pop(m_axis_tready),
    .dout_valid(m_axis_tvalid),
    .dout(head),
    .room(room)
  );

  // lowest bits first: name byte, size, alignment, offset, total
  assign m_axis_tdata = {head.buffer_total, head.param_offset, head.param_alignment,
                         head.param_bytes, head.name_char};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

// File: tb/kernel_param_decl_parser_test.sv
// self-checking testbench for the kernel parameter declaration parser
`timescale 1ns / 1ps

module kernel_param_decl_parser_test;
  import kpd_pkg::*;

  localparam int IDLE_LIMIT = 3000;   // cycles with no request moved on either side
  localparam int TAIL_CYCLES = 8;     // margin past the event latency
  localparam int RANDOM_BYTES = 1600;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;    // text_byte
  logic         s_axis_tlast = 1'b0;  // end_of_text
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;         // name_char, param_bytes, param_alignment,
                                      // param_offset, buffer_total
  logic [1:0]   m_axis_tuser;         // event_kind
  logic         m_axis_tlast;         // run_last

  kernel_param_decl_parser dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // parser model: own copy of the parse state
  // ---------------------------------------------------------------
  logic [4:0]  pm_mode;
  logic [2:0]  pm_kwp;
  logic [7:0]  pm_tchars [4];
  logic [2:0]  pm_tlen;
  logic        pm_tlong;
  logic [31:0] pm_size;
  logic [31:0] pm_count;
  logic [31:0] pm_offset;
  logic        pm_named;

  evt_t byte_events [$];     // events caused by the byte being predicted
  evt_t expected_events [$]; // events still owed by the block

  int errors = 0;
  int bytes_sent = 0;

  function automatic bit ws_char(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit digit_char(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit word_char(logic [7:0] c);
    return digit_char(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function void push_event(logic [1:0] k, logic [7:0] ch, logic [31:0] b,
                           logic [31:0] a, logic [31:0] o, logic [31:0] t);
    evt_t e;
    e.kind = k; e.name_char = ch; e.param_bytes = b; e.param_alignment = a;
    e.param_offset = o; e.buffer_total = t; e.last = 1'b0;
    if (byte_events.size() < 2) byte_events.insert(byte_events.size(), e);
  endfunction

  function void add_type_char(logic [7:0] c);
    if (pm_tlen < 4) begin
      pm_tchars[pm_tlen[1:0]] = c;
      pm_tlen++;
    end else begin
      pm_tlong = 1'b1;
    end
  endfunction

  // size table keyed by the packed token characters
  function void finish_type();
    logic [31:0] k;
    k = '0;
    for (int i = 0; i < pm_tlen; i++) k = {k[23:0], pm_tchars[i]};
    pm_size = 32'd8;
    if (!pm_tlong) begin
      case (k)
        32'("u8"), 32'("s8"), 32'("b8"): pm_size = 32'd1;
        32'("u16"), 32'("s16"), 32'("b16"), 32'("f16"): pm_size = 32'd2;
        32'("u32"), 32'("s32"), 32'("b32"), 32'("f32"): pm_size = 32'd4;
        32'("u128"), 32'("b128"): pm_size = 32'd16;
        default: pm_size = 32'd8;
      endcase
    end
  endfunction

  function void emit_param();
    logic [31:0] al;
    logic [31:0] off;
    al = (pm_size > 32'd4) ? pm_size : 32'd4;
    off = (pm_offset + al - 32'd1) & ~(al - 32'd1);
    pm_offset = off + pm_size;
    if (pm_named) push_event(EV_PARAM, 8'd0, pm_size, al, off, 32'd0);
  endfunction

  function void kernel_end();
    if (pm_named) push_event(EV_END, 8'd0, 32'd0, 32'd0, 32'd0,
                             (pm_offset + 32'd7) & ~32'd7);
    pm_mode = M_SEARCH;
    pm_kwp = '0;
  endfunction

  function void apply_count();
    if (pm_count > 32'd1) pm_size = pm_size * pm_count;
  endfunction

  function void close_array();
    apply_count();
    emit_param();
    pm_mode = M_TOP;
  endfunction

  function void add_digit(logic [7:0] c);
    pm_count = pm_count * 32'd10 + {24'd0, c - 8'd48};
  endfunction

  function void parse_char(logic [7:0] c);
    bit again;
    again = 1'b1;
    for (int pass = 0; pass < 8 && again; pass++) begin
      again = 1'b0;
      case (pm_mode)
        M_SEARCH: begin
          if (pm_kwp < 6 && c == KW_ENTRY[pm_kwp]) begin
            pm_kwp++;
            if (pm_kwp == 6) begin
              pm_mode = M_ENTRY_WS;
              pm_named = 1'b0;
            end
          end else begin
            pm_kwp = (c == ".") ? 3'd1 : 3'd0;
          end
        end
        M_ENTRY_WS: begin
          if (!ws_char(c)) begin
            if (c == "(") begin
              pm_offset = '0; pm_mode = M_TOP;
            end else begin
              pm_named = 1'b1;
              push_event(EV_NAME, c, 32'd0, 32'd0, 32'd0, 32'd0);
              pm_mode = M_NAME;
            end
          end
        end
        M_NAME: begin
          if (c == "(") begin
            pm_offset = '0; pm_mode = M_TOP;
          end else if (ws_char(c)) pm_mode = M_TO_PAREN;
          else push_event(EV_NAME, c, 32'd0, 32'd0, 32'd0, 32'd0);
        end
        M_TO_PAREN: begin
          if (c == "(") begin
            pm_offset = '0; pm_mode = M_TOP;
          end
        end
        M_TOP: begin
          if (c == ")" || c == "{") kernel_end();
          else if (ws_char(c) || c == ",") begin
          end else if (c == ".") begin
            pm_mode = M_PKW; pm_kwp = 3'd1;
          end else pm_mode = M_SKIP;
        end
        M_SKIP: begin
          if (c == ",") pm_mode = M_TOP;
          else if (c == ")") kernel_end();
        end
        M_PKW: begin
          if (pm_kwp < 6 && c == KW_PARAM[pm_kwp]) begin
            pm_kwp++;
            if (pm_kwp == 6) pm_mode = M_AFTER_P;
          end else begin
            pm_mode = M_SKIP; again = 1'b1;
          end
        end
        M_AFTER_P: begin
          if (!ws_char(c)) begin
            if (c == ".") begin
              pm_mode = M_AKW; pm_kwp = 3'd1; pm_tlen = '0; pm_tlong = 1'b0;
            end else begin
              pm_mode = M_TOP; again = 1'b1;
            end
          end
        end
        M_AKW: begin
          if (pm_kwp < 6 && c == KW_ALIGN[pm_kwp]) begin
            add_type_char(c);
            pm_kwp++;
            if (pm_kwp == 6) pm_mode = M_AWS1;
          end else if (word_char(c)) begin
            add_type_char(c); pm_mode = M_TYPE;
          end else begin
            finish_type(); pm_mode = M_PNAME; again = 1'b1;
          end
        end
        M_AWS1: begin
          if (!ws_char(c)) begin
            if (digit_char(c)) pm_mode = M_ADIG;
            else begin
              pm_mode = M_AWS2; again = 1'b1;
            end
          end
        end
        M_ADIG: begin
          if (!digit_char(c)) begin
            pm_mode = M_AWS2; again = 1'b1;
          end
        end
        M_AWS2: begin
          if (!ws_char(c)) begin
            if (c == ".") begin
              pm_tlen = '0; pm_tlong = 1'b0; pm_mode = M_TYPE;
            end else begin
              pm_mode = M_TOP; again = 1'b1;
            end
          end
        end
        M_TYPE: begin
          if (word_char(c)) add_type_char(c);
          else begin
            finish_type(); pm_mode = M_PNAME; again = 1'b1;
          end
        end
        M_PNAME: begin
          if (c == "," || c == ")" || c == "{") begin
            emit_param(); pm_mode = M_TOP; again = 1'b1;
          end else if (c == "[") begin
            pm_count = '0; pm_mode = M_AR_WS;
          end
        end
        M_AR_WS: begin
          if (c == "]") close_array();
          else if (ws_char(c)) begin
          end else if (c == "+") pm_mode = M_AR_POS;
          else if (c == "-") pm_mode = M_AR_NEG;
          else if (digit_char(c)) begin
            add_digit(c); pm_mode = M_AR_POS;
          end else pm_mode = M_AR_DONE;
        end
        M_AR_POS: begin
          if (digit_char(c)) add_digit(c);
          else if (c == "]") close_array();
          else pm_mode = M_AR_DONE;
        end
        M_AR_NEG: begin
          if (digit_char(c)) add_digit(c);
          else begin
            pm_count = 32'd0 - pm_count;
            if (c == "]") close_array();
            else pm_mode = M_AR_DONE;
          end
        end
        M_AR_DONE: if (c == "]") close_array();
        default: begin
          pm_mode = M_SEARCH; pm_kwp = '0;
        end
      endcase
    end
  endfunction

  // end of text flushes a parameter in progress and closes the kernel
  function void finish_text();
    case (pm_mode)
      M_TOP, M_SKIP, M_PKW, M_AFTER_P, M_AWS1, M_ADIG, M_AWS2: kernel_end();
      M_AKW, M_TYPE: begin
        finish_type(); emit_param(); kernel_end();
      end
      M_PNAME: begin
        emit_param(); kernel_end();
      end
      M_AR_NEG: begin
        pm_count = 32'd0 - pm_count;
        apply_count(); emit_param(); kernel_end();
      end
      M_AR_WS, M_AR_POS, M_AR_DONE: begin
        apply_count(); emit_param(); kernel_end();
      end
      default: begin
      end
    endcase
    pm_mode = M_SEARCH;
    pm_kwp = '0;
  endfunction

  function void predict_byte(logic [7:0] c, logic eot);
    byte_events.delete();
    parse_char(c);
    if (eot) finish_text();
    if (byte_events.size() > 0) byte_events[byte_events.size() - 1].last = 1'b1;
    foreach (byte_events[i]) expected_events.insert(expected_events.size(), byte_events[i]);
  endfunction

  // ---------------------------------------------------------------
  // sender: bursts of random length with random gaps
  // ---------------------------------------------------------------
  int burst_left = 0;
  bit bursty = 1'b1;

  task automatic send_byte(logic [7:0] b, logic eot);
    int gap;
    if (bursty && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= eot;
    do @(posedge clk); while (!s_axis_tready);
    if (burst_left > 0) burst_left--;
    predict_byte(b, eot);
    bytes_sent++;
  endtask

  task automatic send_text(string s, bit eot);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eot && i == s.len() - 1);
  endtask

  // waits until every owed event has come, then past the pipeline
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------
  // receiver: stall pattern plus an optional long hold-off
  // ---------------------------------------------------------------
  rx_mode_e rx_mode = RX_ALWAYS;
  int hold_req = 0;
  int hold_left = 0;
  int rx_phase = 0;

  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: m_axis_tready <= 1'b1;
        RX_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= (rx_phase % 7) < 4;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // checker: each event against the oldest expectation
  // ---------------------------------------------------------------
  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
  endtask

  always @(posedge clk) begin
    evt_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_events.size() == 0) begin
        report("unexpected event kind", 32'(m_axis_tuser), 32'hFFFF_FFFF);
      end else begin
        e = expected_events.pop_front();
        if (m_axis_tuser != e.kind)
          report("event_kind", 32'(m_axis_tuser), 32'(e.kind));
        if (m_axis_tdata[7:0] != e.name_char)
          report("name_char", 32'(m_axis_tdata[7:0]), 32'(e.name_char));
        if (m_axis_tdata[39:8] != e.param_bytes)
          report("param_bytes", m_axis_tdata[39:8], e.param_bytes);
        if (m_axis_tdata[71:40] != e.param_alignment)
          report("param_alignment", m_axis_tdata[71:40], e.param_alignment);
        if (m_axis_tdata[103:72] != e.param_offset)
          report("param_offset", m_axis_tdata[103:72], e.param_offset);
        if (m_axis_tdata[135:104] != e.buffer_total)
          report("buffer_total", m_axis_tdata[135:104], e.buffer_total);
        if (m_axis_tlast != e.last)
          report("run_last", 32'(m_axis_tlast), 32'(e.last));
      end
    end
  end

  // watchdog: no request moved on either side for too long
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("kernel_param_decl_parser_test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // random text pieces
  // ---------------------------------------------------------------
  string type_names [] = '{"u8", "s8", "b8", "u16", "s16", "b16", "f16", "u32", "s32",
                           "b32", "f32", "u64", "s64", "b64", "f64", "u128", "b128",
                           "pred", "u256", "x", "U32"};

  function automatic string rand_ws(int lo);
    string s;
    int n;
    s = "";
    n = $urandom_range(lo, 2);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: s = {s, "\t"};
        1: s = {s, "\n"};
        2: s = {s, $sformatf("%c", 8'd11)};
        3: s = {s, $sformatf("%c", 8'd12)};
        4: s = {s, "\r"};
        default: s = {s, " "};
      endcase
    end
    return s;
  endfunction

  function automatic string rand_word(int lo, int hi);
    string s;
    string pool;
    s = "";
    pool = "abcxyzKQ_0179";
    for (int i = $urandom_range(lo, hi); i > 0; i--)
      s = {s, $sformatf("%c", pool[$urandom_range(0, pool.len() - 1)])};
    return s;
  endfunction

  function automatic string rand_number();
    if ($urandom_range(0, 9) == 0) return $sformatf("%0d", $urandom);
    return $sformatf("%0d", $urandom_range(0, 12));
  endfunction

  function automatic string rand_param();
    string s;
    case ($urandom_range(0, 19))
      0: return ".para x";                 // broken keyword
      1: return ".param x";                // no type token
      2: return "junk{tok";                // unknown token
      3: return ".paramx.u16 q";           // keyword prefix
      default: begin
      end
    endcase
    s = {".param", rand_ws(0)};
    if ($urandom_range(0, 2) == 0) s = {s, ".align", rand_ws(1), rand_number(), rand_ws(1)};
    s = {s, ".", type_names[$urandom_range(0, type_names.size() - 1)]};
    if ($urandom_range(0, 3) != 0) s = {s, rand_ws(1), rand_word(1, 4)};
    if ($urandom_range(0, 2) == 0) begin
      s = {s, "[", rand_ws(0)};
      case ($urandom_range(0, 4))
        0: s = {s, "+"};
        1: s = {s, "-"};
        default: begin
        end
      endcase
      if ($urandom_range(0, 7) != 0) s = {s, rand_number()};
      if ($urandom_range(0, 9) == 0) s = {s, "z"};
      s = {s, "]"};
    end
    return s;
  endfunction

  function automatic string rand_kernel();
    string s;
    s = {rand_word(0, 3), rand_ws(0), ".entry", rand_ws(1)};
    if ($urandom_range(0, 7) != 0) s = {s, rand_word(1, 5), rand_ws(0)};
    s = {s, "("};
    for (int i = $urandom_range(0, 4); i > 0; i--)
      s = {s, rand_ws(0), rand_param(), (i > 1) ? "," : ""};
    return {s, rand_ws(0), ($urandom_range(0, 1) != 0) ? ")" : "{"};
  endfunction

  // ---------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------
  task automatic test_directed_basic();
    rx_mode = RX_ALWAYS;
    bursty = 1'b0;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    // two params, one an array with a size that is not a power of two
    send_text(".entry k(.param .align 8 .u8 a[5], .param .b128 z)", 1'b0);
    send_text(".entry (.param .u32 q){", 1'b0);                  // empty name
    send_text(".entry n(.param .s64 p[-2],.param .pred t,", 1'b0); // negative count
    send_text("bad{x,.param.u16)", 1'b0);                        // '{' inside token
    drain();
  endtask

  task automatic test_directed_ends();
    rx_mode = RX_RANDOM;
    bursty = 1'b1;
    send_text(".entry early", 1'b1);             // text ends before '('
    send_text(".entry m(.param .u32 v[ -3", 1'b1); // ends inside a negative count
    send_text(".entry r(.param .f16", 1'b1);       // ends inside the type
    send_byte(8'hA5, 1'b1);
    drain();
  endtask

  task automatic test_random();
    int start;
    string s;
    int cut;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 15) == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        bursty = $urandom_range(0, 3) != 0;
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          for (int i = $urandom_range(1, 8); i > 0; i--)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end
        2: begin
          s = rand_kernel();
          cut = $urandom_range(1, s.len());
          send_text(s.substr(0, cut - 1), 1'b1);
        end
        default: send_text(rand_kernel(), $urandom_range(0, 2) == 0);
      endcase
    end
  endtask

  // receiver holds off while the sender keeps offering bytes
  task automatic test_backpressure();
    rx_mode = RX_ALWAYS;
    bursty = 1'b0;
    hold_req = 400;
    send_text(".entry longname(.param .u32 a,.param .u64 b[3],.param .u8 c)", 1'b1);
    send_text(".entry w(.param .f32 d)", 1'b0);
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    pm_mode = M_SEARCH; pm_kwp = '0; pm_tlen = '0; pm_tlong = 1'b0;
    pm_size = '0; pm_count = '0; pm_offset = '0; pm_named = 1'b0;
    foreach (pm_tchars[i]) pm_tchars[i] = '0;
    test_directed_basic();
    test_directed_ends();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0) begin
      $display("kernel_param_decl_parser_test passed");
    end else begin
      $display("kernel_param_decl_parser_test failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/kpd_pkg.sv
hdl/kpd_parse.sv
hdl/kpd_queue.sv
hdl/kernel_param_decl_parser.sv
tb/kernel_param_decl_parser_test.sv
